// ----- src/tec_pkg.sv -----
package tec_pkg;

    // Result classes.
    localparam logic [1:0] CLASS_ANSI    = 2'd0;
    localparam logic [1:0] CLASS_UTF8    = 2'd1;
    localparam logic [1:0] CLASS_UTF16LE = 2'd2;
    localparam logic [1:0] CLASS_RAW     = 2'd3;

    // Byte order mark lengths.
    localparam logic [1:0] OFFSET_NONE  = 2'd0;
    localparam logic [1:0] OFFSET_UTF16 = 2'd2;
    localparam logic [1:0] OFFSET_UTF8  = 2'd3;

    // Byte order mark bytes.
    localparam logic [7:0] BOM16_B0 = 8'hff;
    localparam logic [7:0] BOM16_B1 = 8'hfe;
    localparam logic [7:0] BOM8_B0  = 8'hef;
    localparam logic [7:0] BOM8_B1  = 8'hbb;
    localparam logic [7:0] BOM8_B2  = 8'hbf;

    // Continuation bytes have the form 10xxxxxx.
    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_MATCH = 8'h80;

    // Byte positions; the position counter saturates at POS_LATER.
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_LATER  = 2'd3;

    typedef struct packed {
        logic [1:0] text_class;
        logic [1:0] payload_offset;
    } result_t;

    // Number of continuation bytes announced by a lead byte (lenient ranges).
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b <= 8'h7f) begin
            len = 3'd0;
        end else if (b <= 8'hdf) begin
            len = 3'd1;
        end else if (b <= 8'hef) begin
            len = 3'd2;
        end else if (b <= 8'hf7) begin
            len = 3'd3;
        end else if (b <= 8'hfb) begin
            len = 3'd4;
        end else if (b <= 8'hfd) begin
            len = 3'd5;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

endpackage

// ----- src/tec_scan.sv -----
module tec_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              empty_buffer,
    output tec_pkg::result_t  result
);

    logic [2:0] pending_reg, pending_next, pending_upd;
    logic       invalid_reg, invalid_next, invalid_upd;
    logic       zero_reg, zero_next, zero_upd;
    logic [1:0] pos_reg, pos_next;
    logic [7:0] first_reg, first_next, first_upd;
    logic [7:0] second_reg, second_next, second_upd;
    logic       mark_third_ok;
    logic [7:0] b1;
    logic       is_cont;
    logic       clear;

    always_comb begin
        // Byte order mark bookkeeping.
        first_upd  = first_reg;
        second_upd = second_reg;
        if (pos_reg == tec_pkg::POS_FIRST) begin
            first_upd = data_byte;
        end else if (pos_reg == tec_pkg::POS_SECOND) begin
            second_upd = data_byte;
        end else if (pos_reg == tec_pkg::POS_THIRD) begin
            if (data_byte != tec_pkg::BOM8_B2 && first_reg == tec_pkg::BOM8_B0) begin
                first_upd = 8'h00;
            end
        end
        mark_third_ok = (pos_reg == tec_pkg::POS_THIRD) ? (data_byte == tec_pkg::BOM8_B2)
                                                         : (first_upd == tec_pkg::BOM8_B0);
        b1 = (pos_reg != tec_pkg::POS_FIRST) ? second_upd : 8'h00;

        // Sequence tracking stops once a bad continuation is seen.
        is_cont     = (data_byte & tec_pkg::CONT_MASK) == tec_pkg::CONT_MATCH;
        zero_upd    = zero_reg | (data_byte == 8'h00);
        pending_upd = pending_reg;
        invalid_upd = invalid_reg;
        if (!invalid_reg) begin
            if (pending_reg != 3'd0) begin
                if (is_cont) begin
                    pending_upd = pending_reg - 3'd1;
                end else if (data_byte != 8'h00) begin
                    invalid_upd = 1'b1;
                end
            end else begin
                pending_upd = tec_pkg::lead_length(data_byte);
            end
        end

        // Classification of the buffer ending with this byte.
        result.payload_offset = tec_pkg::OFFSET_NONE;
        if (empty_buffer) begin
            result.text_class = tec_pkg::CLASS_ANSI;
        end else if (pos_reg != tec_pkg::POS_FIRST && first_upd == tec_pkg::BOM16_B0
                     && b1 == tec_pkg::BOM16_B1) begin
            result.text_class     = tec_pkg::CLASS_UTF16LE;
            result.payload_offset = tec_pkg::OFFSET_UTF16;
        end else if ((pos_reg == tec_pkg::POS_THIRD || pos_reg == tec_pkg::POS_LATER)
                     && first_upd == tec_pkg::BOM8_B0 && b1 == tec_pkg::BOM8_B1
                     && mark_third_ok) begin
            result.text_class     = tec_pkg::CLASS_UTF8;
            result.payload_offset = tec_pkg::OFFSET_UTF8;
        end else if (zero_upd) begin
            result.text_class = tec_pkg::CLASS_RAW;
        end else if (invalid_upd) begin
            result.text_class = tec_pkg::CLASS_ANSI;
        end else if (pending_upd != 3'd0) begin
            result.text_class = tec_pkg::CLASS_RAW;
        end else begin
            result.text_class = tec_pkg::CLASS_UTF8;
        end

        // A finished or empty buffer leaves the state clear for the next one.
        clear = empty_buffer | last_byte;
        if (!step) begin
            pending_next = pending_reg;
            invalid_next = invalid_reg;
            zero_next    = zero_reg;
            pos_next     = pos_reg;
            first_next   = first_reg;
            second_next  = second_reg;
        end else if (clear) begin
            pending_next = 3'd0;
            invalid_next = 1'b0;
            zero_next    = 1'b0;
            pos_next     = tec_pkg::POS_FIRST;
            first_next   = 8'h00;
            second_next  = 8'h00;
        end else begin
            pending_next = pending_upd;
            invalid_next = invalid_upd;
            zero_next    = zero_upd;
            pos_next     = (pos_reg == tec_pkg::POS_LATER) ? pos_reg : pos_reg + 2'd1;
            first_next   = first_upd;
            second_next  = second_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 3'd0;
            invalid_reg <= 1'b0;
            zero_reg    <= 1'b0;
            pos_reg     <= tec_pkg::POS_FIRST;
            first_reg   <= 8'h00;
            second_reg  <= 8'h00;
        end else begin
            pending_reg <= pending_next;
            invalid_reg <= invalid_next;
            zero_reg    <= zero_next;
            pos_reg     <= pos_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
        end
    end

endmodule

// ----- src/text_encoding_classifier_top.sv -----
// Text encoding classifier: a buffer enters as a stream of byte requests on
// the s_ channel, one byte per request, with s_last_byte set on its final
// byte. A request with s_empty_buffer set stands for a buffer with no bytes.
// The final byte (or the empty request) produces one result request on the
// m_ channel carrying the class (ANSI, UTF-8, UTF-16LE or raw binary) and the
// number of byte order mark bytes to skip. Other bytes produce no result.
// The scan logic classifies each byte from the input register, and a result
// is written to the output register as its final or empty byte leaves the
// input register.
// Throughput: one byte per cycle unless a final byte is held back; the
// scan state is a handful of small registers, one logic pass per byte.
// When the receiver stalls, the pending result stays in the output register
// and one more byte waits in the input register; bytes that give no result
// keep moving. s_ready drops only when a final byte is held behind a result
// that has not been taken.
// Reset (aresetn low at a clock edge) empties both registers and clears the
// scan state, so the next byte is treated as the first of a buffer.
module text_encoding_classifier_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    input  logic       s_empty_buffer,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_text_class,
    output logic [1:0] m_payload_offset
);

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       empty_reg;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    tec_pkg::result_t  out_reg;
    tec_pkg::result_t  scan_result;

    logic produces;
    logic out_free;
    logic advance;

    // A byte leaves the input register when it gives no result, or when the
    // output register is empty or being emptied in this cycle.
    assign produces = last_reg | empty_reg;
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!produces || out_free);
    assign s_ready  = !in_valid_reg || advance;

    tec_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .data_byte    (data_reg),
        .last_byte    (last_reg),
        .empty_buffer (empty_reg),
        .result       (scan_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && produces) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg  <= s_data_byte;
            last_reg  <= s_last_byte;
            empty_reg <= s_empty_buffer;
        end
        if (advance && produces) begin
            out_reg <= scan_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_text_class     = out_reg.text_class;
    assign m_payload_offset = out_reg.payload_offset;

`ifndef SYNTHESIS
    // A new result only appears after a final or empty byte left the input
    // register.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_valid_reg && (last_reg || empty_reg)))
        else $error("result appeared without a final byte");

    // An empty buffer always classifies as ANSI with no mark to skip.
    a_empty_ansi: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && empty_reg) |=> (m_valid && m_text_class == tec_pkg::CLASS_ANSI
                                    && m_payload_offset == tec_pkg::OFFSET_NONE))
        else $error("empty buffer did not give ANSI");

    // A nonzero offset only comes with the class of the matching mark.
    a_offset_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload_offset == tec_pkg::OFFSET_NONE
                     || (m_payload_offset == tec_pkg::OFFSET_UTF16
                         && m_text_class == tec_pkg::CLASS_UTF16LE)
                     || (m_payload_offset == tec_pkg::OFFSET_UTF8
                         && m_text_class == tec_pkg::CLASS_UTF8)))
        else $error("offset does not match class");

    // A stalled result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_reg)))
        else $error("stalled result was overwritten");
`endif

endmodule

// ----- tb/encoding_result_checker.sv -----
module encoding_result_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    input  logic       s_empty_buffer,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [1:0] m_text_class,
    input  logic [1:0] m_payload_offset,
    output int         mismatch_count,
    output int         results_waiting
);

    // Scan state of the buffer currently being classified.
    logic [2:0] cont_left;
    logic       bad_seq;
    logic       zero_byte_seen;
    logic [1:0] byte_idx;
    logic [7:0] head0;
    logic [7:0] head1;

    tec_pkg::result_t expected_class_q[$];
    tec_pkg::result_t want;
    tec_pkg::result_t got;
    tec_pkg::result_t next_class;
    logic             class_due;
    int               mismatch_total = 0;

    assign mismatch_count = mismatch_total;

    task automatic report_mismatch(input string what);
        $display("checker: %0t: %s", $time, what);
        mismatch_total++;
    endtask

    task automatic clear_scan();
        cont_left      = 3'd0;
        bad_seq        = 1'b0;
        zero_byte_seen = 1'b0;
        byte_idx       = tec_pkg::POS_FIRST;
        head0          = 8'h00;
        head1          = 8'h00;
    endtask

    // Continuation bytes announced by a lead byte, with the lenient ranges.
    function automatic logic [2:0] seq_cont_count(input logic [7:0] b);
        if (b < 8'h80) return 3'd0;
        if (b < 8'he0) return 3'd1;
        if (b < 8'hf0) return 3'd2;
        if (b < 8'hf8) return 3'd3;
        if (b < 8'hfc) return 3'd4;
        if (b < 8'hfe) return 3'd5;
        return 3'd0;
    endfunction

    task automatic scan_byte(input logic [7:0] b, input logic last, input logic empty,
                             output logic produced, output tec_pkg::result_t res);
        logic [1:0] idx;
        logic       bom_tail_ok;
        logic [7:0] h1;
        produced = 1'b0;
        res      = '0;
        if (empty) begin
            clear_scan();
            produced           = 1'b1;
            res.text_class     = tec_pkg::CLASS_ANSI;
            res.payload_offset = tec_pkg::OFFSET_NONE;
            return;
        end
        idx = byte_idx;
        case (idx)
            tec_pkg::POS_FIRST: begin
                head0 = b;
            end
            tec_pkg::POS_SECOND: begin
                head1 = b;
            end
            tec_pkg::POS_THIRD: begin
                if (b != tec_pkg::BOM8_B2 && head0 == tec_pkg::BOM8_B0) head0 = 8'h00;
            end
            default: ;
        endcase
        bom_tail_ok = (idx == tec_pkg::POS_THIRD) ? (b == tec_pkg::BOM8_B2)
                                                  : (head0 == tec_pkg::BOM8_B0);

        if (b == 8'h00) zero_byte_seen = 1'b1;
        if (!bad_seq) begin
            if (cont_left != 3'd0) begin
                if ((b & tec_pkg::CONT_MASK) == tec_pkg::CONT_MATCH) begin
                    cont_left = cont_left - 3'd1;
                end else if (b != 8'h00) begin
                    bad_seq = 1'b1;
                end
            end else begin
                cont_left = seq_cont_count(b);
            end
        end
        if (idx != tec_pkg::POS_LATER) byte_idx = idx + 2'd1;
        if (!last) return;

        h1 = (idx != tec_pkg::POS_FIRST) ? head1 : 8'h00;
        produced           = 1'b1;
        res.payload_offset = tec_pkg::OFFSET_NONE;
        if (idx != tec_pkg::POS_FIRST && head0 == tec_pkg::BOM16_B0
            && h1 == tec_pkg::BOM16_B1) begin
            res.text_class     = tec_pkg::CLASS_UTF16LE;
            res.payload_offset = tec_pkg::OFFSET_UTF16;
        end else if (idx >= tec_pkg::POS_THIRD && head0 == tec_pkg::BOM8_B0
                     && h1 == tec_pkg::BOM8_B1 && bom_tail_ok) begin
            res.text_class     = tec_pkg::CLASS_UTF8;
            res.payload_offset = tec_pkg::OFFSET_UTF8;
        end else if (zero_byte_seen) begin
            res.text_class = tec_pkg::CLASS_RAW;
        end else if (bad_seq) begin
            res.text_class = tec_pkg::CLASS_ANSI;
        end else if (cont_left != 3'd0) begin
            res.text_class = tec_pkg::CLASS_RAW;
        end else begin
            res.text_class = tec_pkg::CLASS_UTF8;
        end
        clear_scan();
    endtask

    // A result leaves only after its byte passed both registers, so the output
    // side is checked before the byte accepted at the same edge is scanned.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_scan();
            expected_class_q.delete();
            results_waiting <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got.text_class     = m_text_class;
                got.payload_offset = m_payload_offset;
                if (expected_class_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result class %0d offset %0d",
                                              got.text_class, got.payload_offset));
                end else begin
                    want = expected_class_q.pop_front();
                    if (got.text_class != want.text_class)
                        report_mismatch($sformatf("text_class %0d, wanted %0d",
                                                  got.text_class, want.text_class));
                    if (got.payload_offset != want.payload_offset)
                        report_mismatch($sformatf("payload_offset %0d, wanted %0d",
                                                  got.payload_offset, want.payload_offset));
                end
            end
            if (s_valid && s_ready) begin
                scan_byte(s_data_byte, s_last_byte, s_empty_buffer, class_due, next_class);
                if (class_due) expected_class_q.push_back(next_class);
            end
            results_waiting <= expected_class_q.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

    // Cycles without any accepted request on either channel before the run
    // is declared hung. The longest legitimate quiet stretch is the receiver
    // hold-off below, so this leaves a wide margin.
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DIRECTED_REQS = 25;
    localparam int PHASE_REQS    = 490;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte    = 8'h00;
    logic       s_last_byte    = 1'b0;
    logic       s_empty_buffer = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [1:0] m_text_class;
    logic [1:0] m_payload_offset;

    int         mismatch_count;
    int         results_waiting;

    // Idle rates in percent, changed per phase by the stimulus process.
    int         tx_idle_pct  = 0;
    int         rx_stall_pct = 0;
    int         rx_hold_len  = 0;
    int         hold_left;
    int         reqs_sent    = 0;
    int         quiet_cycles = 0;
    int         phase_goal;

    // Bytes of the buffer that is about to be sent.
    logic [7:0] text_q[$];

    always #5 aclk = ~aclk;

    text_encoding_classifier_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .s_empty_buffer   (s_empty_buffer),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_text_class     (m_text_class),
        .m_payload_offset (m_payload_offset)
    );

    // The checker watches both channels, predicts every classification and
    // compares; this module only produces traffic and reports the verdict.
    encoding_result_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .s_empty_buffer   (s_empty_buffer),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_text_class     (m_text_class),
        .m_payload_offset (m_payload_offset),
        .mismatch_count   (mismatch_count),
        .results_waiting  (results_waiting)
    );

    // Sends one request. Idle cycles are inserted first, then valid is raised
    // and held with a stable payload until the request is taken. The task
    // returns at the edge where the request was accepted, so the caller may
    // drive the next request (or drop valid) in that same time step.
    task automatic send_req(input logic [7:0] data, input logic last, input logic empty);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= data;
        s_last_byte    <= last;
        s_empty_buffer <= empty;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        reqs_sent++;
    endtask

    // Sends the queued buffer with the last flag on its final byte.
    task automatic send_text();
        foreach (text_q[i]) send_req(text_q[i], i == text_q.size() - 1, 1'b0);
    endtask

    // The sender goes quiet until every predicted result has come back. The
    // waiting count from the checker is registered, so the sender waits on the
    // clock before it is looked at.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_waiting != 0);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hbf));
    endfunction

    // A lead byte announcing the given number of continuation bytes, using
    // the lenient ranges the block accepts (up to six-byte sequences).
    function automatic logic [7:0] lead_byte(input int conts);
        case (conts)
            1:       return 8'($urandom_range(8'h80, 8'hdf));
            2:       return 8'($urandom_range(8'he0, 8'hef));
            3:       return 8'($urandom_range(8'hf0, 8'hf7));
            4:       return 8'($urandom_range(8'hf8, 8'hfb));
            default: return 8'($urandom_range(8'hfc, 8'hfd));
        endcase
    endfunction

    function automatic int pick_conts();
        return ($urandom_range(99) < 70) ? $urandom_range(1, 3) : $urandom_range(4, 5);
    endfunction

    task automatic append_seq(input int conts, input int keep);
        text_q.push_back(lead_byte(conts));
        repeat (keep) text_q.push_back(cont_byte());
    endtask

    // Well-formed text: nonzero ASCII mixed with complete multibyte runs.
    task automatic append_text(input int units);
        int n;
        repeat (units) begin
            if ($urandom_range(99) < 60) begin
                text_q.push_back(8'($urandom_range(1, 127)));
            end else begin
                n = pick_conts();
                append_seq(n, n);
            end
        end
    endtask

    // Builds one random buffer. Most are well-formed, some with a byte order
    // mark in front; the rest are cut short, carry a bad continuation or a
    // zero byte, are short fragments of the marks, or plain random bytes.
    task automatic make_text();
        int kind;
        int n;
        kind = $urandom_range(99);
        text_q.delete();
        if (kind < 55) begin
            if ($urandom_range(3) == 0) begin
                if ($urandom_range(1) == 0) begin
                    text_q.push_back(8'hef);
                    text_q.push_back(8'hbb);
                    text_q.push_back(8'hbf);
                end else begin
                    text_q.push_back(8'hff);
                    text_q.push_back(8'hfe);
                end
            end
            append_text($urandom_range(1, 6));
        end else if (kind < 75) begin
            append_text($urandom_range(0, 4));
            case ($urandom_range(2))
                0: begin
                    // Sequence cut short at the end of the buffer.
                    n = pick_conts();
                    append_seq(n, $urandom_range(0, n - 1));
                end
                1: begin
                    // Lead byte followed by a byte that is not a continuation.
                    text_q.push_back(lead_byte(pick_conts()));
                    if ($urandom_range(1) == 0)
                        text_q.push_back(8'($urandom_range(1, 127)));
                    else
                        text_q.push_back(8'($urandom_range(8'hc0, 8'hff)));
                    append_text($urandom_range(0, 3));
                end
                default: begin
                    append_text($urandom_range(1, 4));
                    text_q.insert($urandom_range(0, text_q.size()), 8'h00);
                end
            endcase
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(6))
                    0:       text_q.push_back(8'hef);
                    1:       text_q.push_back(8'hbb);
                    2:       text_q.push_back(8'hbf);
                    3:       text_q.push_back(8'hff);
                    4:       text_q.push_back(8'hfe);
                    5:       text_q.push_back(8'h00);
                    default: text_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Receiver. Normally ready is drawn at random each cycle at the current
    // stall rate. When a hold-off is requested, ready stays low while its
    // length is counted down here, so the block fills up and pushes back.
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_len != 0) begin
                m_ready     <= 1'b0;
                hold_left   = rx_hold_len;
                rx_hold_len = 0;
                while (hold_left != 0) begin
                    @(posedge aclk);
                    hold_left--;
                end
            end else begin
                m_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed buffers. An empty request wins over a set last flag.
        send_req(8'hff, 1'b1, 1'b1);
        // UTF-16LE mark alone.
        text_q = '{8'hff, 8'hfe};
        send_text();
        // UTF-8 mark followed by text.
        text_q = '{8'hef, 8'hbb, 8'hbf, 8'h41};
        send_text();
        // First two bytes of the UTF-8 mark only: too short for the mark,
        // and the lead byte is left waiting for a continuation.
        text_q = '{8'hef, 8'hbb};
        send_text();
        // Third byte breaks the mark and is a bad continuation.
        text_q = '{8'hef, 8'hbb, 8'h41};
        send_text();
        // A zero byte makes the buffer raw binary.
        text_q = '{8'h00, 8'h7f};
        send_text();
        // Bad continuation after a two-byte lead.
        text_q = '{8'hc3, 8'h41};
        send_text();
        // Longest lenient sequence, complete, with continuation extremes.
        text_q = '{8'hfc, 8'h80, 8'hbf, 8'h80, 8'h80, 8'h80};
        send_text();
        // Lead byte with nothing after it.
        text_q = '{8'he0};
        send_text();
        // A lone FF is a single byte, not a mark.
        text_q = '{8'hff};
        send_text();
        // Empty request without the last flag.
        send_req(8'h00, 1'b0, 1'b1);
        wait_for_drain();

        // Random phases: no idling, sender mostly idle, receiver mostly
        // stalled, then both idling now and then.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 78; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 78; end
                default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
            endcase
            phase_goal = DIRECTED_REQS + (phase + 1) * PHASE_REQS;

            // In the first phase the receiver holds off for a long stretch
            // while short buffers keep arriving back to back.
            if (phase == 0) begin
                rx_hold_len = HOLD_CYCLES;
                repeat (30) begin
                    text_q.delete();
                    append_text(1);
                    send_text();
                end
            end

            while (reqs_sent < phase_goal) begin
                if ($urandom_range(99) < 8) begin
                    send_req(8'($urandom_range(0, 255)), 1'($urandom_range(1)),
                             $urandom_range(99) < 40);
                end else begin
                    make_text();
                    send_text();
                end
            end
            wait_for_drain();
        end

        // Everything has come back; run the clock on before the verdict so a
        // stray extra result would still be seen.
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
